@@ hw/rtl/brgl_pkg.sv @@
// package for the block range group lookup core
// holds item structs, command and status codes, table sizing and the range match function
// no dependencies
package brgl_pkg;

    // table sizing
    localparam int MAX_GROUPS = 256;
    localparam int IDX_W      = $clog2(MAX_GROUPS);
    localparam int CNT_W      = IDX_W + 1;

    // command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] range_start;
        logic [31:0] range_blocks;
        logic [63:0] query_block;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] group_index;
    } out_item_t;

    // one stored range
    typedef struct packed {
        logic [63:0] start;
        logic [31:0] blocks;
    } entry_t;

    // start <= blk < start + blocks, with no wrap
    function automatic logic range_holds(entry_t e, logic [63:0] blk);
        logic [64:0] diff;
        diff = {1'b0, blk} - {1'b0, e.start};
        return !diff[64] && (diff[63:32] == 32'd0) && (diff[31:0] < e.blocks);
    endfunction

    // table index to the 8-bit result field (low bits kept)
    function automatic logic [7:0] index_field(logic [IDX_W-1:0] idx);
        logic [IDX_W+7:0] wide;
        wide = {8'd0, idx};
        return wide[7:0];
    endfunction

endpackage

@@ hw/rtl/brgl_cell.sv @@
// one cell of the range table ring: holds a single stored range
// takes a direct write on append, else the neighbor's range while the ring turns
// depends on brgl_pkg
module brgl_cell (
    input  logic            clk,
    input  logic            wr_en,
    input  brgl_pkg::entry_t wr_data,
    input  logic            shift_en,
    input  brgl_pkg::entry_t shift_in,
    output brgl_pkg::entry_t entry
);
    import brgl_pkg::*;

    entry_t entry_reg;

    // entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
        else if (shift_en)
        begin
            entry_reg <= shift_in;
        end
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/brgl_chain.sv @@
// ring of range cells with an append write decoder
// cell 0 is the head; each turn step moves every range one cell toward the head
// depends on brgl_pkg, brgl_cell
module brgl_chain (
    input  logic                       clk,
    input  logic                       append_en,
    input  logic [brgl_pkg::IDX_W-1:0] append_idx,
    input  brgl_pkg::entry_t           append_data,
    input  logic                       turn_en,
    output brgl_pkg::entry_t           head
);
    import brgl_pkg::*;

    entry_t cell_entry [MAX_GROUPS];

    // row of cells closed into a ring
    for (genvar i = 0; i < MAX_GROUPS; i++)
    begin : g_cell
        localparam int             NEXT     = (i + 1) % MAX_GROUPS;
        localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);

        logic wr_sel;

        // write decode for this cell's fixed position
        assign wr_sel = append_en && (append_idx == CELL_IDX);

        brgl_cell u_cell (
            .clk      (clk),
            .wr_en    (wr_sel),
            .wr_data  (append_data),
            .shift_en (turn_en),
            .shift_in (cell_entry[NEXT]),
            .entry    (cell_entry[i])
        );
    end

    assign head = cell_entry[0];

endmodule

@@ hw/rtl/block_range_group_lookup_core.sv @@
// top level of the block range group lookup core
// command control, last-hit cache and scan sequencing over the range ring
// depends on brgl_pkg, brgl_chain
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  request  | start / busy       | cmd, range_start, range_blocks, query_block
//  result   | done (one cycle)   | status, group_index
//
// clear, append and a lookup that hits the cached last entry: result on done in the
// cycle after the item is taken, busy stays low.
// a lookup that misses the cache turns the ring one full circle, comparing the head
// cell each cycle; busy is high for the whole scan and drops as done is strobed.
// reset clears the entry count and the cache; stored ranges need no clearing.
// done is a one-cycle strobe, the receiver cannot stall it.
module block_range_group_lookup_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  brgl_pkg::in_item_t   request,
    output logic                 done,
    output brgl_pkg::out_item_t  result
);
    import brgl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic              cache_valid_reg, cache_valid_next;
    logic [IDX_W-1:0]  cache_idx_reg, cache_idx_next;
    entry_t            cache_entry_reg, cache_entry_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [63:0]       query_reg, query_next;
    logic              done_reg, done_next;
    out_item_t         result_reg, result_next;

    logic              append_en;
    logic              turn_en;
    logic              scan_hit;
    logic [IDX_W-1:0]  hit_idx;
    entry_t            append_data;
    entry_t            head;

    // range ring
    assign append_data.start  = request.range_start;
    assign append_data.blocks = request.range_blocks;

    brgl_chain u_chain (
        .clk         (clk),
        .append_en   (append_en),
        .append_idx  (used_reg[IDX_W-1:0]),
        .append_data (append_data),
        .turn_en     (turn_en),
        .head        (head)
    );

    // head compare during the scan, first hit below the entry count only
    assign scan_hit = !found_reg && ({1'b0, scan_idx_reg} < used_reg)
                      && range_holds(head, query_reg);
    assign hit_idx  = scan_hit ? scan_idx_reg : found_idx_reg;

    // command and scan control
    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        cache_valid_next = cache_valid_reg;
        cache_idx_next   = cache_idx_reg;
        cache_entry_next = cache_entry_reg;
        scan_idx_next    = scan_idx_reg;
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        query_next       = query_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        append_en        = 1'b0;
        turn_en          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    result_next.status      = STAT_OK;
                    result_next.group_index = 8'd0;
                    unique case (request.cmd)
                        CMD_CLEAR:
                        begin
                            used_next        = '0;
                            cache_valid_next = 1'b0;
                            cache_idx_next   = '0;
                            done_next        = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (used_reg == CNT_W'(MAX_GROUPS))
                            begin
                                result_next.status = STAT_FULL;
                            end
                            else
                            begin
                                append_en = 1'b1;
                                used_next = used_reg + 1'b1;
                            end
                            done_next = 1'b1;
                        end
                        CMD_LOOKUP:
                        begin
                            if (cache_valid_reg
                                && range_holds(cache_entry_reg, request.query_block))
                            begin
                                result_next.group_index = index_field(cache_idx_reg);
                                done_next               = 1'b1;
                            end
                            else
                            begin
                                query_next    = request.query_block;
                                scan_idx_next = '0;
                                found_next    = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                turn_en = 1'b1;
                if (scan_hit)
                begin
                    found_next       = 1'b1;
                    found_idx_next   = scan_idx_reg;
                    cache_valid_next = 1'b1;
                    cache_idx_next   = scan_idx_reg;
                    cache_entry_next = head;
                end
                // last step brings the ring back to its home alignment
                if (scan_idx_reg == IDX_W'(MAX_GROUPS - 1))
                begin
                    done_next = 1'b1;
                    if (found_reg || scan_hit)
                    begin
                        result_next.status      = STAT_OK;
                        result_next.group_index = index_field(hit_idx);
                    end
                    else
                    begin
                        result_next.status      = STAT_NOT_FOUND;
                        result_next.group_index = 8'd0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= '0;
            cache_valid_reg <= 1'b0;
            cache_idx_reg   <= '0;
            scan_idx_reg    <= '0;
            found_reg       <= 1'b0;
            found_idx_reg   <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            cache_valid_reg <= cache_valid_next;
            cache_idx_reg   <= cache_idx_next;
            scan_idx_reg    <= scan_idx_next;
            found_reg       <= found_next;
            found_idx_reg   <= found_idx_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cache_entry_reg <= cache_entry_next;
        query_reg       <= query_next;
    end

    assign busy   = (state_reg == S_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ test/tb_top.sv @@
// testbench for block_range_group_lookup_core: clear, append and lookup items checked against
// an in-bench range table with a last-hit cache, under bursty start and random gaps
// depends on brgl_pkg and block_range_group_lookup_core
module tb_top;

    import brgl_pkg::*;

    // unused command code: the block leaves the table as it is and returns STAT_OK
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [63:0] TOP_BLOCK = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS   = 750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 300;

    // pending item with an optional wait for all results before it goes out
    typedef struct {
        in_item_t item;
        bit       hold;
    } pend_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_item_t  request = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    pend_t     pend_q[$];
    out_item_t want_q[$];
    int        err_count = 0;
    int        n_taken = 0;
    int        n_returned = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        idle_cycles = 0;

    // predicted range table and cache
    logic [63:0] tbl_start [MAX_GROUPS];
    logic [31:0] tbl_len [MAX_GROUPS];
    int          tbl_used = 0;
    bit          cache_ok = 1'b0;
    int          cache_idx = 0;

    // stimulus-side copy of the table, used to aim lookups at stored ranges
    logic [63:0] plan_start [MAX_GROUPS];
    logic [31:0] plan_len [MAX_GROUPS];
    int          plan_used = 0;
    int          n_real = 0;

    block_range_group_lookup_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    // block lies in [start, start + len) of one predicted entry, no wrap
    function automatic bit covers(int idx, logic [63:0] blk);
        logic [63:0] off;
        if (blk < tbl_start[idx])
            return 1'b0;
        off = blk - tbl_start[idx];
        return off < {32'd0, tbl_len[idx]};
    endfunction

    // apply one item to the predicted table and return its result
    function automatic out_item_t predict_result(in_item_t it);
        out_item_t r;
        int        hit;
        r.status      = STAT_OK;
        r.group_index = '0;
        hit           = -1;
        case (it.cmd)
            CMD_CLEAR:
            begin
                tbl_used  = 0;
                cache_ok  = 1'b0;
                cache_idx = 0;
            end
            CMD_APPEND:
            begin
                if (tbl_used >= MAX_GROUPS)
                    r.status = STAT_FULL;
                else
                begin
                    tbl_start[tbl_used] = it.range_start;
                    tbl_len[tbl_used]   = it.range_blocks;
                    tbl_used++;
                end
            end
            CMD_LOOKUP:
            begin
                if (cache_ok && cache_idx < tbl_used && covers(cache_idx, it.query_block))
                    hit = cache_idx;
                else
                begin
                    for (int i = 0; i < tbl_used; i++)
                    begin
                        if (covers(i, it.query_block))
                        begin
                            hit       = i;
                            cache_ok  = 1'b1;
                            cache_idx = i;
                            break;
                        end
                    end
                end
                if (hit < 0)
                    r.status = STAT_NOT_FOUND;
                else
                    r.group_index = 8'(hit);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // range start: near the top of the block space, anywhere, or a small crowded region
    function automatic logic [63:0] rand_range_start();
        case ($urandom_range(0, 7))
            0: return TOP_BLOCK - 64'($urandom_range(0, 1000));
            1: return rand64();
            default: return 64'($urandom_range(0, 4000));
        endcase
    endfunction

    function automatic logic [31:0] rand_range_len();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 300));
        endcase
    endfunction

    // block on or next to the edges of a planned entry, or inside it
    function automatic logic [63:0] near_block(int idx);
        logic [63:0] s;
        logic [63:0] n;
        s = plan_start[idx];
        n = {32'd0, plan_len[idx]};
        case ($urandom_range(0, 5))
            0: return s - 64'd1;
            1: return s;
            2: return s + n - 64'd1;
            3: return s + n;
            default: return (n == 0) ? s : s + 64'($urandom % plan_len[idx]);
        endcase
    endfunction

    // queue one item and track what the table will hold
    task automatic push_item(logic [1:0] c, logic [63:0] rs, logic [31:0] rb,
                             logic [63:0] qb, bit hold);
        pend_t p;
        p.item.cmd          = c;
        p.item.range_start  = rs;
        p.item.range_blocks = rb;
        p.item.query_block  = qb;
        p.hold              = hold;
        pend_q.push_back(p);
        if (c == CMD_CLEAR)
            plan_used = 0;
        else if (c == CMD_APPEND && plan_used < MAX_GROUPS)
        begin
            plan_start[plan_used] = rs;
            plan_len[plan_used]   = rb;
            plan_used++;
        end
        if (c != CMD_UNUSED)
            n_real++;
    endtask

    task automatic push_append(logic [63:0] rs, logic [31:0] rb, bit hold);
        push_item(CMD_APPEND, rs, rb, rand64(), hold);
    endtask

    task automatic push_lookup(logic [63:0] qb, bit hold);
        push_item(CMD_LOOKUP, rand64(), $urandom, qb, hold);
    endtask

    // stimulus, reset and end of run
    initial
    begin
        bit did_full;
        bit full_ep;
        bit hold;
        int n_app;
        int n_look;
        int idx;
        int lo;

        // directed: empty table, zero-length and top-of-space ranges, overlap and cache
        push_lookup(64'd0, 1'b0);
        push_item(CMD_UNUSED, rand64(), $urandom, rand64(), 1'b0);
        push_append(64'd0, 32'd0, 1'b0);
        push_append(TOP_BLOCK, 32'hFFFF_FFFF, 1'b0);
        push_append(64'd100, 32'd10, 1'b0);
        push_append(64'd105, 32'd20, 1'b0);
        push_lookup(64'd0, 1'b0);
        push_lookup(TOP_BLOCK, 1'b0);
        push_lookup(64'd99, 1'b0);
        push_lookup(64'd100, 1'b0);
        push_lookup(64'd109, 1'b0);
        push_lookup(64'd110, 1'b0);
        push_lookup(64'd107, 1'b0);
        push_lookup(64'd125, 1'b0);
        push_item(CMD_UNUSED, rand64(), $urandom, rand64(), 1'b0);
        push_lookup(64'd124, 1'b0);
        push_item(CMD_CLEAR, rand64(), $urandom, rand64(), 1'b0);
        push_lookup(64'd107, 1'b0);
        push_append(64'd107, 32'd1, 1'b0);
        push_lookup(64'd107, 1'b0);
        push_append(64'd0, 32'hFFFF_FFFF, 1'b0);
        push_lookup(64'h0000_0000_FFFF_FFFE, 1'b0);
        push_lookup(64'h0000_0000_FFFF_FFFF, 1'b0);

        // random episodes: optional clear, a run of appends, then mostly aimed lookups
        n_real   = 0;
        did_full = 1'b0;
        hold     = 1'b1;
        while (n_real < RANDOM_ITEMS)
        begin
            full_ep = !did_full && n_real > 200;
            if (full_ep)
                did_full = 1'b1;
            if (full_ep || $urandom_range(0, 4) != 0)
            begin
                push_item(CMD_CLEAR, rand64(), $urandom, rand64(), hold);
                hold = 1'b0;
            end
            // full episode runs past the table size to hit the full case
            n_app = full_ep ? MAX_GROUPS + 2 : $urandom_range(1, 12);
            for (int k = 0; k < n_app; k++)
            begin
                push_append(rand_range_start(), rand_range_len(), hold);
                hold = 1'b0;
            end
            n_look = full_ep ? 40 : $urandom_range(8, 30);
            for (int k = 0; k < n_look; k++)
            begin
                case ($urandom_range(0, 19))
                    0: push_item(CMD_UNUSED, rand64(), $urandom, rand64(), 1'b0);
                    1: push_append(rand_range_start(), rand_range_len(), 1'b0);
                    2: push_lookup(rand64(), 1'b0);
                    3: push_lookup(64'($urandom_range(0, 4500)), 1'b0);
                    default:
                    begin
                        if (plan_used == 0)
                            push_lookup(64'($urandom_range(0, 4500)), 1'b0);
                        else
                        begin
                            lo  = (full_ep && plan_used > 40) ? plan_used - 40 : 0;
                            idx = $urandom_range(lo, plan_used - 1);
                            push_lookup(near_block(idx), 1'b0);
                        end
                    end
                endcase
            end
            hold = ($urandom_range(0, 3) == 0);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last item to go out and every result to return
        while (pend_q.size() != 0 || start || want_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (want_q.size() != 0)
        begin
            void'(want_q.pop_front());
            report_mismatch("expected result never came");
        end
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // driver: bursts of items with random gaps, holds an item until start is taken
    always @(posedge clk)
    begin
        bit took;
        took = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want_q.push_back(predict_result(request));
                void'(pend_q.pop_front());
                n_taken++;
                took = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(50, 300);
                        default: gap_left = $urandom_range(1, 5);
                    endcase
                end
            end
            if (!(start && !took))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pend_q.size() == 0 || (pend_q[0].hold && n_taken != n_returned))
                    start <= 1'b0;
                else
                begin
                    start   <= 1'b1;
                    request <= pend_q[0].item;
                end
            end
        end
    end

    // monitor: each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (want_q.size() == 0)
                report_mismatch($sformatf("result with no item pending, status %0d index %0d",
                                          result.status, result.group_index));
            else
            begin
                want = want_q.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
                if (result.group_index !== want.group_index)
                    report_mismatch($sformatf("group_index got %0d want %0d",
                                              result.group_index, want.group_index));
            end
            n_returned <= n_returned + 1;
        end
    end

    // watchdog on cycles with no item taken and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
